FILE: hdl/qs_pkg.sv
// Package for the quicksort engine: sizes and sequencer states.
// No dependencies.
`default_nettype none
package qs_pkg;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int KEY_BITS_DEF     = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_WR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_PUSH,
        ST_READ_RD,
        ST_READ_OUT
    } qs_state_t;
endpackage
`default_nettype wire

FILE: hdl/quicksort_engine.sv
// Quicksort engine top level: key store, range stack and sort sequencer.
// Depends on qs_pkg and qs_ram.
//
// channel | dir | tdata (low bit up)                   | tuser
// s_axis  | in  | key[KEY_BITS-1:0]                    | op
// m_axis  | out | sorted_key[KEY_BITS-1:0]             | is_last, empty_res
//
// Append writes the key store as the key is accepted. A read passes ST_READ_RD,
// the registered key store read port and ST_READ_OUT. The first read after
// loading runs the sort: per range ST_POP to ST_PIVOT, a scan read and compare per
// element, ST_SWAP_WR per swap, ST_FIN_RD to ST_PUSH; s_tready is low throughout.
// No clearing pass at reset; only control registers are reset.
// A waiting result holds m_axis_tdata stable; the block takes no input until taken.
`default_nettype none
module quicksort_engine
    import qs_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    input  wire logic [((KEY_BITS+7)/8)*8-1:0] s_axis_tdata, // key
    input  wire logic s_axis_tuser,                          // op
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    output logic [((KEY_BITS+7)/8)*8-1:0] m_axis_tdata,      // sorted_key
    output logic [1:0] m_axis_tuser                          // is_last, empty_res
);
    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = AW + 1;
    localparam int SD  = MAX_ELEMENTS / 2 + 1;
    localparam int SAW = $clog2(SD);
    localparam int SCW = SAW + 1;
    localparam int DW  = ((KEY_BITS + 7) / 8) * 8;

    qs_state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next, rptr_reg, rptr_next;
    logic           done_reg, done_next;
    logic [SCW-1:0] top_reg, top_next;
    // signed-ish indexes kept as CW+1 bits so lo-1 is representable
    logic [CW:0] lo_reg, lo_next, hi_reg, hi_next, i_reg, i_next, j_reg, j_next;
    logic [KEY_BITS-1:0] pivot_reg, pivot_next, kj_reg, kj_next;
    logic        push2_reg, push2_next;
    logic        mvalid_reg, mvalid_next;
    logic [KEY_BITS-1:0] mkey_reg, mkey_next;
    logic        mlast_reg, mlast_next, mempty_reg, mempty_next;

    logic            k_we;
    logic [AW-1:0]   k_waddr, k_ra, k_rb;
    logic [KEY_BITS-1:0] k_wdata, k_qa, k_qb;
    logic            s_we;
    logic [SAW-1:0]  s_waddr, s_raddr;
    logic [2*CW-1:0] s_wdata, s_q, s_q_unused;

    qs_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ELEMENTS)) u_keys (
        .aclk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr_a(k_ra), .rdata_a(k_qa), .raddr_b(k_rb), .rdata_b(k_qb));
    qs_ram #(.WIDTH(2*CW), .DEPTH(SD)) u_stack (
        .aclk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr_a(s_raddr), .rdata_a(s_q), .raddr_b(s_raddr), .rdata_b(s_q_unused));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rptr_reg   <= '0;
            done_reg   <= 1'b0;
            top_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rptr_reg   <= rptr_next;
            done_reg   <= done_next;
            top_reg    <= top_next;
            mvalid_reg <= mvalid_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pivot_reg <= pivot_next;
        kj_reg    <= kj_next;
        push2_reg <= push2_next;
        mkey_reg  <= mkey_next;
        mlast_reg <= mlast_next;
        mempty_reg <= mempty_next;
    end

    logic [CW:0] p_w;
    assign p_w = i_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rptr_next  = rptr_reg;
        done_next  = done_reg;
        top_next   = top_reg;
        lo_next = lo_reg; hi_next = hi_reg; i_next = i_reg; j_next = j_reg;
        pivot_next = pivot_reg;
        kj_next    = kj_reg;
        push2_next = push2_reg;
        mvalid_next = mvalid_reg;
        mkey_next  = mkey_reg;
        mlast_next = mlast_reg;
        mempty_next = mempty_reg;
        s_axis_tready = 1'b0;
        k_we = 1'b0; k_waddr = '0; k_wdata = '0;
        k_ra = '0; k_rb = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_raddr = SAW'(top_reg - 1'b1);

        if (mvalid_reg && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = !mvalid_reg;
                if (s_axis_tvalid && s_axis_tready) begin
                    if (!s_axis_tuser) begin
                        if (done_reg) begin
                            done_next = 1'b0;
                            rptr_next = '0;
                            k_we = 1'b1;
                            k_waddr = '0;
                            k_wdata = s_axis_tdata[KEY_BITS-1:0];
                            count_next = CW'(1);
                        end else if (count_reg < CW'(MAX_ELEMENTS)) begin
                            k_we = 1'b1;
                            k_waddr = count_reg[AW-1:0];
                            k_wdata = s_axis_tdata[KEY_BITS-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end else if (!done_reg) begin
                        done_next = 1'b1;
                        rptr_next = '0;
                        if (count_reg >= CW'(2)) begin
                            s_we = 1'b1;
                            s_waddr = '0;
                            s_wdata = {CW'(0), CW'(count_reg - 1'b1)};
                            top_next = SCW'(1);
                            state_next = ST_POP;
                        end else begin
                            top_next = '0;
                            state_next = ST_READ_RD;
                        end
                    end else begin
                        state_next = ST_READ_RD;
                    end
                end
            end
            ST_POP: begin
                if (top_reg == '0) begin
                    state_next = ST_READ_RD;
                end else begin
                    s_raddr = SAW'(top_reg - 1'b1);
                    top_next = top_reg - 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                lo_next = {1'b0, s_q[2*CW-1:CW]};
                hi_next = {1'b0, s_q[CW-1:0]};
                k_ra = s_q[AW-1:0];
                state_next = ST_PIVOT;
            end
            ST_PIVOT: begin
                pivot_next = k_qa;
                i_next = lo_reg - 1'b1;
                j_next = lo_reg;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                if (j_reg < hi_reg) begin
                    k_ra = j_reg[AW-1:0];
                    k_rb = p_w[AW-1:0];
                    state_next = ST_SCAN_CMP;
                end else begin
                    k_ra = p_w[AW-1:0];
                    state_next = ST_FIN_RD;
                end
            end
            ST_SCAN_CMP: begin
                if (k_qa <= pivot_reg) begin
                    // key_store[i+1] -> slot j, key j -> slot i+1
                    kj_next = k_qa;
                    k_we = 1'b1;
                    k_waddr = j_reg[AW-1:0];
                    k_wdata = k_qb;
                    i_next = p_w;
                    state_next = ST_SWAP_WR;
                end else begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SWAP_WR: begin
                k_we = 1'b1;
                k_waddr = i_reg[AW-1:0];
                k_wdata = kj_reg;
                j_next = j_reg + 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_FIN_RD: begin
                // k_qa = key_store[p]; pivot is key_store[hi]
                k_we = 1'b1;
                k_waddr = hi_reg[AW-1:0];
                k_wdata = k_qa;
                kj_next = pivot_reg;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                k_we = 1'b1;
                k_waddr = p_w[AW-1:0];
                k_wdata = kj_reg;
                push2_next = (p_w + 1'b1) < hi_reg;
                // p may be 0, so compare against lo+1 rather than p-1
                if (p_w > (lo_reg + 1'b1)) begin
                    s_we = 1'b1;
                    s_waddr = top_reg[SAW-1:0];
                    s_wdata = {lo_reg[CW-1:0], CW'(p_w - 1'b1)};
                    top_next = top_reg + 1'b1;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (push2_reg) begin
                    s_we = 1'b1;
                    s_waddr = top_reg[SAW-1:0];
                    s_wdata = {CW'(p_w + 1'b1), hi_reg[CW-1:0]};
                    top_next = top_reg + 1'b1;
                end
                state_next = ST_POP;
            end
            ST_READ_RD: begin
                k_ra = rptr_reg[AW-1:0];
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT: begin
                mvalid_next = 1'b1;
                if (rptr_reg < count_reg) begin
                    mkey_next = k_qa;
                    mlast_next = (rptr_reg == count_reg - 1'b1);
                    mempty_next = 1'b0;
                    rptr_next = rptr_reg + 1'b1;
                end else begin
                    mkey_next = '0;
                    mlast_next = 1'b0;
                    mempty_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = DW'(mkey_reg);
    assign m_axis_tuser  = {mempty_reg, mlast_reg};
endmodule
`default_nettype wire

FILE: hdl/qs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module qs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire
